>>> design/ascii_hex_frame_encoder_defines.svh
`ifndef ASCII_HEX_FRAME_ENCODER_DEFINES_SVH
`define ASCII_HEX_FRAME_ENCODER_DEFINES_SVH

// same-cycle check: when cond holds, expr must hold too
`define AHFE_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle check: when cond holds, expr must hold in the cycle after
`define AHFE_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

>>> design/ahfe_pkg.sv
`default_nettype none

package ahfe_pkg;

  // frame control characters
  localparam logic [7:0] STX_CHAR = 8'h02;
  localparam logic [7:0] ETX_CHAR = 8'h03;
  localparam logic [7:0] MISUSE_CHAR = 8'h00;

  // input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // register index (address bit 2)
  localparam logic REG_PLAIN_TYPE   = 1'b0;
  localparam logic REG_SECURED_TYPE = 1'b1;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // character counter inside one job
  localparam int STEP_W = 4;

  typedef enum logic [1:0] {
    JOB_START,
    JOB_DATA,
    JOB_MISUSE
  } job_kind_t;

  // one classified transaction, ready to be spelled out
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] b0;     // start: type, data: payload byte
    logic [7:0] b1;     // start: sequence
    logic [7:0] b2;     // start: length
    logic       close;  // checksum and ETX follow
    logic [7:0] csum;   // inverted additive sum
  } job_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // uppercase ascii hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_char = 8'h30 + wide;
    end else begin
      hex_char = 8'h37 + wide;
    end
  endfunction

endpackage

`default_nettype wire

>>> design/ahfe_front.sv
`default_nettype none

module ahfe_front (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    opcode,
  input  wire                    secured,
  input  wire  [7:0]             frame_length,
  input  wire  [7:0]             data_byte,
  input  wire  [7:0]             plain_type,
  input  wire  [7:0]             secured_type,
  input  ahfe_pkg::queue_status_t q_status,
  output logic                   push,
  output ahfe_pkg::job_t         push_job
);

  logic [7:0] seq_r, seq_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] left_r, left_nxt;
  logic       open_r, open_nxt;

  logic [7:0] seq_inc;
  logic [7:0] type_sel;
  logic [7:0] seq_sel;
  logic [7:0] sum_start;
  logic [7:0] sum_data;
  logic [7:0] left_dec;

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  // header bytes and running sums
  assign seq_inc   = seq_r + 8'd1;
  assign type_sel  = secured ? secured_type : plain_type;
  assign seq_sel   = secured ? seq_inc : 8'h00;
  assign sum_start = type_sel + seq_sel + frame_length;
  assign sum_data  = sum_r + data_byte;
  assign left_dec  = left_r - 8'd1;

  // classify the transaction and update frame state
  always_comb begin
    seq_nxt  = seq_r;
    sum_nxt  = sum_r;
    left_nxt = left_r;
    open_nxt = open_r;
    push_job = '0;
    if (opcode == ahfe_pkg::OP_START) begin
      push_job.kind  = ahfe_pkg::JOB_START;
      push_job.b0    = type_sel;
      push_job.b1    = seq_sel;
      push_job.b2    = frame_length;
      push_job.close = (frame_length == 8'd0);
      push_job.csum  = ~sum_start;
      if (push) begin
        if (secured) begin
          seq_nxt = seq_inc;
        end
        if (frame_length == 8'd0) begin
          sum_nxt  = 8'h00;
          left_nxt = 8'h00;
          open_nxt = 1'b0;
        end else begin
          sum_nxt  = sum_start;
          left_nxt = frame_length;
          open_nxt = 1'b1;
        end
      end
    end else if (!open_r) begin
      push_job.kind = ahfe_pkg::JOB_MISUSE;
    end else begin
      push_job.kind  = ahfe_pkg::JOB_DATA;
      push_job.b0    = data_byte;
      push_job.close = (left_dec == 8'd0);
      push_job.csum  = ~sum_data;
      if (push) begin
        if (left_dec == 8'd0) begin
          sum_nxt  = 8'h00;
          left_nxt = 8'h00;
          open_nxt = 1'b0;
        end else begin
          sum_nxt  = sum_data;
          left_nxt = left_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= 8'h00;
      sum_r  <= 8'h00;
      left_r <= 8'h00;
      open_r <= 1'b0;
    end else begin
      seq_r  <= seq_nxt;
      sum_r  <= sum_nxt;
      left_r <= left_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/ahfe_queue.sv
`default_nettype none

module ahfe_queue (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  input  ahfe_pkg::job_t          push_job,
  input  wire                     pop,
  output ahfe_pkg::job_t          pop_job,
  output ahfe_pkg::queue_status_t status
);

  ahfe_pkg::job_t                 slot_r [ahfe_pkg::QUEUE_DEPTH];
  logic [ahfe_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [ahfe_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [ahfe_pkg::QCNT_W-1:0]    count_r, count_nxt;
  logic                           do_push;
  logic                           do_pop;

  localparam logic [ahfe_pkg::QPTR_W-1:0] LAST_PTR =
    ahfe_pkg::QPTR_W'(ahfe_pkg::QUEUE_DEPTH - 1);
  localparam logic [ahfe_pkg::QCNT_W-1:0] FULL_CNT =
    ahfe_pkg::QCNT_W'(ahfe_pkg::QUEUE_DEPTH);

  assign status.full  = (count_r == FULL_CNT);
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_job      = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

>>> design/ahfe_back.sv
`default_nettype none

module ahfe_back (
  input  wire                     clk,
  input  wire                     rst_n,
  input  ahfe_pkg::queue_status_t q_status,
  input  ahfe_pkg::job_t          pop_job,
  output logic                    pop,
  output logic                    busy,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [7:0]              out_char,
  output logic                    out_last,
  output logic                    out_done,
  output logic                    out_misuse
);

  localparam logic [ahfe_pkg::STEP_W-1:0] START_OPEN_END  = 4'd6;
  localparam logic [ahfe_pkg::STEP_W-1:0] START_CLOSE_END = 4'd9;
  localparam logic [ahfe_pkg::STEP_W-1:0] DATA_OPEN_END   = 4'd1;
  localparam logic [ahfe_pkg::STEP_W-1:0] DATA_CLOSE_END  = 4'd4;

  ahfe_pkg::job_t              job_r, job_nxt;
  logic                        busy_r, busy_nxt;
  logic [ahfe_pkg::STEP_W-1:0] step_r, step_nxt;

  logic                        ov_r, ov_nxt;
  logic [7:0]                  char_r;
  logic                        last_r, done_r, misuse_r;

  logic                        load;
  logic [7:0]                  cur_char;
  logic                        cur_last;
  logic                        cur_done;
  logic                        cur_misuse;

  assign busy       = busy_r;
  assign out_valid  = ov_r;
  assign out_char   = char_r;
  assign out_last   = last_r;
  assign out_done   = done_r;
  assign out_misuse = misuse_r;

  // one character per cycle into the output register, while out_ready does not stall it
  assign load = busy_r && (!ov_r || out_ready);
  assign pop  = !q_status.empty && (!busy_r || (load && cur_last));

  // character for the current step of the job
  always_comb begin
    cur_char   = ahfe_pkg::MISUSE_CHAR;
    cur_last   = 1'b0;
    cur_done   = 1'b0;
    cur_misuse = 1'b0;
    unique case (job_r.kind)
      ahfe_pkg::JOB_START: begin
        cur_last = job_r.close ? (step_r == START_CLOSE_END) : (step_r == START_OPEN_END);
        unique case (step_r)
          4'd0:    cur_char = ahfe_pkg::STX_CHAR;
          4'd1:    cur_char = ahfe_pkg::hex_char(job_r.b0[7:4]);
          4'd2:    cur_char = ahfe_pkg::hex_char(job_r.b0[3:0]);
          4'd3:    cur_char = ahfe_pkg::hex_char(job_r.b1[7:4]);
          4'd4:    cur_char = ahfe_pkg::hex_char(job_r.b1[3:0]);
          4'd5:    cur_char = ahfe_pkg::hex_char(job_r.b2[7:4]);
          4'd6:    cur_char = ahfe_pkg::hex_char(job_r.b2[3:0]);
          4'd7:    cur_char = ahfe_pkg::hex_char(job_r.csum[7:4]);
          4'd8:    cur_char = ahfe_pkg::hex_char(job_r.csum[3:0]);
          default: begin
            cur_char = ahfe_pkg::ETX_CHAR;
            cur_done = 1'b1;
          end
        endcase
      end
      ahfe_pkg::JOB_DATA: begin
        cur_last = job_r.close ? (step_r == DATA_CLOSE_END) : (step_r == DATA_OPEN_END);
        unique case (step_r)
          4'd0:    cur_char = ahfe_pkg::hex_char(job_r.b0[7:4]);
          4'd1:    cur_char = ahfe_pkg::hex_char(job_r.b0[3:0]);
          4'd2:    cur_char = ahfe_pkg::hex_char(job_r.csum[7:4]);
          4'd3:    cur_char = ahfe_pkg::hex_char(job_r.csum[3:0]);
          default: begin
            cur_char = ahfe_pkg::ETX_CHAR;
            cur_done = 1'b1;
          end
        endcase
      end
      default: begin
        cur_last   = 1'b1;
        cur_misuse = 1'b1;
      end
    endcase
  end

  // job sequencing
  always_comb begin
    job_nxt  = job_r;
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (load) begin
      step_nxt = step_r + 1'b1;
    end
    if (pop) begin
      job_nxt  = pop_job;
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (load && cur_last) begin
      busy_nxt = 1'b0;
    end
  end

  // output register valid
  always_comb begin
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (load) begin
      char_r   <= cur_char;
      last_r   <= cur_last;
      done_r   <= cur_done;
      misuse_r <= cur_misuse;
    end
  end

endmodule

`default_nettype wire

>>> design/ascii_hex_frame_encoder.sv
// channel | dir | tdata                               | tuser                      | tlast
// in_     | in  | [7:0] frame_length, [15:8] data_byte | [0] opcode, [1] secured    | -
// out_    | out | [7:0] out_char                      | [0] frame_done, [1] misuse | run_last
// cfg_    | in  | apb, 0x0 plain_frame_type, 0x4 secured_frame_type (8 bits each)
//
// the front takes one input transaction per cycle while the two-entry job queue has room
// the back emits one character per cycle while out_tready holds: a start spells 7 characters (10 if it also
// closes the frame), a payload byte 2 (5 when it closes), a misplaced byte 1
// so a payload stream is paced by the back's output register
// synchronous active-low reset, no clearing pass; a stalled out_ fills the queue, then
// drops in_tready
`default_nettype none
`include "ascii_hex_frame_encoder_defines.svh"

module ascii_hex_frame_encoder (
  input  wire         clk,
  input  wire         rst_n,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [7:0] frame_length, [15:8] data_byte
  input  wire  [1:0]  in_tuser,   // [0] opcode, [1] secured
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_char
  output logic [1:0]  out_tuser,  // [0] frame_done, [1] misuse
  output logic        out_tlast,
  // configuration
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0]              plain_type_r;
  logic [7:0]              secured_type_r;
  logic                    cfg_wr;

  ahfe_pkg::queue_status_t q_status;
  ahfe_pkg::job_t          push_job;
  ahfe_pkg::job_t          pop_job;
  logic                    push;
  logic                    pop;
  logic                    back_busy;
  logic                    done_w;
  logic                    misuse_w;

  // register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plain_type_r   <= 8'h00;
      secured_type_r <= 8'h01;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        ahfe_pkg::REG_PLAIN_TYPE:   plain_type_r   <= cfg_pwdata[7:0];
        ahfe_pkg::REG_SECURED_TYPE: secured_type_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      ahfe_pkg::REG_PLAIN_TYPE:   cfg_prdata = {24'h0, plain_type_r};
      ahfe_pkg::REG_SECURED_TYPE: cfg_prdata = {24'h0, secured_type_r};
      default:                    cfg_prdata = 32'h0;
    endcase
  end

  ahfe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .opcode       (in_tuser[0]),
    .secured      (in_tuser[1]),
    .frame_length (in_tdata[7:0]),
    .data_byte    (in_tdata[15:8]),
    .plain_type   (plain_type_r),
    .secured_type (secured_type_r),
    .q_status     (q_status),
    .push         (push),
    .push_job     (push_job)
  );

  ahfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  ahfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .pop_job    (pop_job),
    .pop        (pop),
    .busy       (back_busy),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_char   (out_tdata),
    .out_last   (out_tlast),
    .out_done   (done_w),
    .out_misuse (misuse_w)
  );

  assign out_tuser = {misuse_w, done_w};

  // checks
  `AHFE_ASSERT_NOW(a_etx_closes, clk, rst_n, out_tvalid && out_tuser[0], out_tlast && (out_tdata == ahfe_pkg::ETX_CHAR), "frame_done without closing ETX")
  `AHFE_ASSERT_NOW(a_etx_flagged, clk, rst_n, out_tvalid && (out_tdata == ahfe_pkg::ETX_CHAR), out_tuser[0] && !out_tuser[1], "ETX without frame_done")
  `AHFE_ASSERT_NOW(a_misuse_single, clk, rst_n, out_tvalid && out_tuser[1], out_tlast && (out_tdata == ahfe_pkg::MISUSE_CHAR), "misuse result not a lone zero")
  `AHFE_ASSERT_NEXT(a_job_held, clk, rst_n, in_tvalid && in_tready, !q_status.empty || back_busy, "accepted transaction lost")

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT  = 3000;  // cycles with no transaction on either side
  localparam int SETTLE_CYCLES = 16;   // block latency margin before a register write / at the end
  localparam logic [7:0] DIGIT_BASE  = 8'h30;  // '0'
  localparam logic [7:0] LETTER_BASE = 8'h41;  // 'A'
  localparam int REPORT_LIMIT = 10;

  // one expected frame character
  typedef struct packed {
    logic [7:0] char_code;
    logic       run_last;
    logic       frame_done;
    logic       misuse;
  } frame_char_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] frame_length, [15:8] data_byte
  logic [1:0]  in_tuser;   // [0] opcode, [1] secured
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] out_char
  logic [1:0]  out_tuser;  // [0] frame_done, [1] misuse
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // encoder mirror: registers and frame state
  logic [7:0]  plain_type;
  logic [7:0]  secured_type;
  logic [7:0]  seq_count;
  logic [7:0]  frame_sum;
  logic [7:0]  bytes_due;
  logic        in_frame;

  frame_char_t pending_chars[$];
  int          fault_count;
  int          items_sent;
  int          quiet_cycles;
  bit          idle_on;
  int          hold_request;

  ascii_hex_frame_encoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ascii hex digit for one nibble
  function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return DIGIT_BASE + {4'h0, nib};
    end else begin
      return LETTER_BASE + {4'h0, nib} - 8'd10;
    end
  endfunction

  function automatic void push_char(input logic [7:0] c, input logic done, input logic bad);
    frame_char_t fc;
    fc.char_code  = c;
    fc.run_last   = 1'b0;
    fc.frame_done = done;
    fc.misuse     = bad;
    pending_chars.push_back(fc);
  endfunction

  function automatic void push_hex(input logic [7:0] value);
    push_char(nibble_ascii(value[7:4]), 1'b0, 1'b0);
    push_char(nibble_ascii(value[3:0]), 1'b0, 1'b0);
  endfunction

  // inverted checksum, then ETX; frame closes
  function automatic void close_frame();
    push_hex(~frame_sum);
    push_char(ahfe_pkg::ETX_CHAR, 1'b1, 1'b0);
    in_frame  = 1'b0;
    bytes_due = 8'd0;
    frame_sum = 8'd0;
  endfunction

  // expected characters for one accepted input transaction
  function automatic void encode_item(input logic op, input logic sec,
                                      input logic [7:0] len, input logic [7:0] dat);
    logic [7:0] kind_byte;
    logic [7:0] seq_byte;
    if (op == ahfe_pkg::OP_START) begin
      if (sec) begin
        seq_count = seq_count + 8'd1;
        kind_byte = secured_type;
        seq_byte  = seq_count;
      end else begin
        kind_byte = plain_type;
        seq_byte  = 8'd0;
      end
      push_char(ahfe_pkg::STX_CHAR, 1'b0, 1'b0);
      push_hex(kind_byte);
      push_hex(seq_byte);
      push_hex(len);
      frame_sum = kind_byte + seq_byte + len;
      bytes_due = len;
      in_frame  = 1'b1;
      if (len == 8'd0) close_frame();
    end else if (!in_frame) begin
      push_char(ahfe_pkg::MISUSE_CHAR, 1'b0, 1'b1);
    end else begin
      push_hex(dat);
      frame_sum = frame_sum + dat;
      bytes_due = bytes_due - 8'd1;
      if (bytes_due == 8'd0) close_frame();
    end
    pending_chars[pending_chars.size() - 1].run_last = 1'b1;
  endfunction

  // offer one input transaction, with an optional random gap first
  task automatic send_item(input logic op, input logic sec,
                           input logic [7:0] len, input logic [7:0] dat);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {dat, len};
    in_tuser  <= {sec, op};
    do @(posedge clk); while (!in_tready);
    encode_item(op, sec, len, dat);
    items_sent++;
  endtask

  // start transaction followed by n_data payload transactions
  task automatic send_frame(input logic sec, input logic [7:0] len, input int n_data);
    send_item(ahfe_pkg::OP_START, sec, len, 8'($urandom));
    for (int i = 0; i < n_data; i++) begin
      send_item(ahfe_pkg::OP_DATA, 1'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // stop offering and let every expected character drain
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup then access cycle
  task automatic write_reg(input logic idx, input logic [7:0] value);
    wait_idle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'h0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == ahfe_pkg::REG_PLAIN_TYPE) begin
      plain_type = value;
    end else begin
      secured_type = value;
    end
    @(posedge clk);
  endtask

  // stray bytes, empty frames, abandoned frames, field extremes at reset types
  task automatic test_directed();
    send_item(ahfe_pkg::OP_DATA, 1'b1, 8'hFF, 8'h5A);   // no frame open
    send_frame(1'b0, 8'd0, 0);                          // empty plain frame
    send_frame(1'b1, 8'd0, 0);                          // empty secured frame
    send_item(ahfe_pkg::OP_START, 1'b1, 8'd1, 8'hFF);
    send_item(ahfe_pkg::OP_DATA, 1'b0, 8'h00, 8'h00);
    send_item(ahfe_pkg::OP_START, 1'b0, 8'd2, 8'h00);
    send_item(ahfe_pkg::OP_DATA, 1'b1, 8'hFF, 8'hFF);
    send_item(ahfe_pkg::OP_DATA, 1'b0, 8'h00, 8'hA5);
    // start while a frame is open abandons it
    send_item(ahfe_pkg::OP_START, 1'b1, 8'd3, 8'h00);
    send_item(ahfe_pkg::OP_DATA, 1'b0, 8'h00, 8'h3C);
    send_item(ahfe_pkg::OP_START, 1'b0, 8'd1, 8'h00);
    send_item(ahfe_pkg::OP_DATA, 1'b0, 8'h00, 8'hC3);
    send_item(ahfe_pkg::OP_DATA, 1'b0, 8'h00, 8'h99);   // frame already closed
    send_item(ahfe_pkg::OP_START, 1'b1, 8'h80, 8'h00);
    send_item(ahfe_pkg::OP_DATA, 1'b1, 8'h7F, 8'h0F);
    send_frame(1'b0, 8'd0, 0);
  endtask

  // both type registers at their extremes
  task automatic test_register_extremes();
    write_reg(ahfe_pkg::REG_PLAIN_TYPE, 8'hFF);
    write_reg(ahfe_pkg::REG_SECURED_TYPE, 8'h00);
    send_frame(1'b0, 8'd2, 2);
    send_frame(1'b1, 8'd0, 0);
    send_frame(1'b1, 8'd3, 3);
    write_reg(ahfe_pkg::REG_PLAIN_TYPE, 8'h00);
    write_reg(ahfe_pkg::REG_SECURED_TYPE, 8'hFF);
    send_frame(1'b0, 8'd0, 0);
    send_frame(1'b1, 8'd2, 2);
  endtask

  // random frames over several register settings; one full-length frame
  task automatic test_random_phases();
    int unsigned len;
    int unsigned pick;
    int          n_data;
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(ahfe_pkg::REG_PLAIN_TYPE, 8'($urandom));
      write_reg(ahfe_pkg::REG_SECURED_TYPE, 8'($urandom));
      if (phase == 2) send_frame(1'($urandom), 8'd255, 255);
      while (items_sent < 47 + 20 * (phase + 1) + ((phase >= 2) ? 256 : 0)) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          // noise: a lone payload transaction
          send_item(ahfe_pkg::OP_DATA, 1'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          if ($urandom_range(0, 7) == 0) begin
            len = 0;
          end else if ($urandom_range(0, 5) == 0) begin
            len = $urandom_range(7, 24);
          end else begin
            len = $urandom_range(1, 6);
          end
          n_data = len;
          if (pick == 1 && len > 1) n_data = $urandom_range(0, len - 1);
          send_frame(1'($urandom), 8'(len), n_data);
        end
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, so the block stalls its input
  task automatic test_backpressure();
    wait_idle();
    idle_on      = 1'b0;
    hold_request = 300;
    send_frame(1'b1, 8'd8, 8);
    send_frame(1'b0, 8'd0, 0);
    idle_on = 1'b1;
  endtask

  // last stretch without any idling on either side
  task automatic test_steady_tail();
    wait_idle();
    idle_on = 1'b0;
    send_frame(1'b1, 8'd6, 6);
    send_frame(1'b0, 8'd0, 0);
    send_frame(1'b0, 8'd12, 12);
    send_item(ahfe_pkg::OP_DATA, 1'b0, 8'h00, 8'h11);
    send_frame(1'b1, 8'd4, 4);
  endtask

  // main sequence
  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    plain_type   = 8'h00;
    secured_type = 8'h01;
    seq_count    = 8'h00;
    frame_sum    = 8'h00;
    bytes_due    = 8'h00;
    in_frame     = 1'b0;
    fault_count  = 0;
    items_sent   = 0;
    idle_on      = 1'b1;
    hold_request = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_random_phases();
    test_backpressure();
    test_steady_tail();

    wait_idle();
    if (fault_count == 0 && pending_chars.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // receiver: random stalls, plus a long hold when asked
  initial begin : sink_proc
    int n;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 17);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare each accepted character with the oldest expectation
  always @(posedge clk) begin
    frame_char_t seen;
    frame_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.char_code  = out_tdata;
      seen.run_last   = out_tlast;
      seen.frame_done = out_tuser[0];
      seen.misuse     = out_tuser[1];
      if (pending_chars.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("unexpected transaction: char %h last %b done %b misuse %b",
                   seen.char_code, seen.run_last, seen.frame_done, seen.misuse);
      end else begin
        want = pending_chars.pop_front();
        if (seen.char_code !== want.char_code || seen.run_last !== want.run_last ||
            seen.frame_done !== want.frame_done || seen.misuse !== want.misuse) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("mismatch: exp char %h last %b done %b misuse %b, got %h %b %b %b",
                     want.char_code, want.run_last, want.frame_done, want.misuse,
                     seen.char_code, seen.run_last, seen.frame_done, seen.misuse);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial quiet_cycles = 0;

endmodule
